[hw/rtl/stereo_gain_clip_peak_meter_assert.svh]
// Assertion macros shared by the gain, clip and peak meter RTL.
`ifndef STEREO_GAIN_CLIP_PEAK_METER_ASSERT_SVH
`define STEREO_GAIN_CLIP_PEAK_METER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SGCPM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SGCPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sgcpm_pkg.sv]
// Types, constants and helper functions for the stereo gain, clip and peak meter.
package sgcpm_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int WORD_W    = 32;
  localparam int GAIN_W    = 15;
  localparam int GAIN_FRAC = 14;
  localparam int SUM_W     = 30;
  localparam int TALLY_W   = 8;
  localparam int INDEX_W   = 7;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

  localparam int CAPTURE_DEPTH_DEFAULT = 128;

  localparam logic [GAIN_W-1:0]          GAIN_RESET  = 15'd8192;
  localparam logic signed [SAMPLE_W-1:0] MAX24       = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] MIN24       = 24'sh800000;
  localparam logic [SUM_W-1:0]           SUM_LIMIT   = {SUM_W{1'b1}};
  localparam logic [TALLY_W-1:0]         TALLY_LIMIT = {TALLY_W{1'b1}};

  typedef struct packed {
    logic signed [WORD_W-1:0] left_word;
    logic signed [WORD_W-1:0] right_word;
    logic                     batch_start;
  } frame_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   left_out;
    logic signed [WORD_W-1:0]   right_out;
    logic [TALLY_W-1:0]         batch_clip_count;
    logic signed [SAMPLE_W-1:0] batch_max;
    logic signed [SAMPLE_W-1:0] batch_min;
    logic [SUM_W-1:0]           batch_abs_sum;
    logic [SAMPLE_W-1:0]        peak_level;
    logic [INDEX_W-1:0]         capture_index;
  } result_t;

  // One channel after gain and clamping, with its clip flag.
  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    logic                     clipped;
  } chan_t;

  // Meter values after the current frame has been taken in.
  typedef struct packed {
    logic [TALLY_W-1:0]         batch_clip_count;
    logic signed [SAMPLE_W-1:0] batch_max;
    logic signed [SAMPLE_W-1:0] batch_min;
    logic [SUM_W-1:0]           batch_abs_sum;
    logic [SAMPLE_W-1:0]        peak_level;
    logic [INDEX_W-1:0]         capture_index;
  } stats_t;

  // Magnitude of a 24-bit sample; the most negative value gives 2^23.
  function automatic logic [SAMPLE_W-1:0] mag24(input logic signed [SAMPLE_W-1:0] s);
    return s[SAMPLE_W-1] ? (~s + 24'd1) : s;
  endfunction

endpackage

[hw/rtl/sgcpm_gain_chan.sv]
// One channel: multiply by the unsigned Q1.14 gain, truncate toward zero and clamp.
module sgcpm_gain_chan (
  input  logic signed [sgcpm_pkg::SAMPLE_W-1:0] sample,
  input  logic [sgcpm_pkg::GAIN_W-1:0]          gain,
  output sgcpm_pkg::chan_t                      chan
);

  localparam int PW = sgcpm_pkg::PROD_W;
  localparam int SW = sgcpm_pkg::SAMPLE_W;
  localparam int VW = PW - sgcpm_pkg::GAIN_FRAC;
  localparam logic signed [PW-1:0] TRUNC_BIAS =
    (PW'(1) <<< sgcpm_pkg::GAIN_FRAC) - PW'(1);
  localparam logic signed [VW-1:0] POS_LIMIT = VW'(sgcpm_pkg::MAX24);
  localparam logic signed [VW-1:0] NEG_LIMIT = -VW'(sgcpm_pkg::MAX24);

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_biased;
  logic signed [VW-1:0] scaled;
  logic signed [SW-1:0] clamped;
  logic                 over;
  logic                 under;

  always_comb begin
    prod = PW'(sample) * $signed({1'b0, gain});
    // Biasing negative products before the shift makes it truncate toward zero.
    prod_biased = prod + (prod[PW-1] ? TRUNC_BIAS : '0);
    scaled = prod_biased[PW-1:sgcpm_pkg::GAIN_FRAC];
    over  = scaled > POS_LIMIT;
    under = scaled < NEG_LIMIT;
    priority if (over) begin
      clamped = sgcpm_pkg::MAX24;
    end else if (under) begin
      clamped = -sgcpm_pkg::MAX24;
    end else begin
      clamped = scaled[SW-1:0];
    end
    chan.word_out = {clamped, 8'h00};
    chan.clipped  = over | under;
  end

endmodule

[hw/rtl/sgcpm_stats.sv]
// Batch statistics, peak hold and capture slot counter.
module sgcpm_stats #(
  parameter int CAPTURE_DEPTH = sgcpm_pkg::CAPTURE_DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic signed [sgcpm_pkg::SAMPLE_W-1:0] left_pcm,
  input  logic signed [sgcpm_pkg::SAMPLE_W-1:0] right_pcm,
  input  logic                                  batch_start,
  input  logic                                  left_clip,
  input  logic                                  right_clip,
  output sgcpm_pkg::stats_t                     stats
);

  `include "stereo_gain_clip_peak_meter_assert.svh"

  localparam int SW     = sgcpm_pkg::SAMPLE_W;
  localparam int TW     = sgcpm_pkg::TALLY_W;
  localparam int UW     = sgcpm_pkg::SUM_W;
  localparam int IW     = sgcpm_pkg::INDEX_W;
  localparam int SLOT_W = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPTURE_DEPTH - 1);

  logic [SW-1:0]        peak_hold;
  logic [SW-1:0]        peak_hold_next;
  logic signed [SW-1:0] running_max;
  logic signed [SW-1:0] running_max_next;
  logic signed [SW-1:0] running_min;
  logic signed [SW-1:0] running_min_next;
  logic [UW-1:0]        running_abs_sum;
  logic [UW-1:0]        running_abs_sum_next;
  logic [TW-1:0]        clip_tally;
  logic [TW-1:0]        clip_tally_next;
  logic [SLOT_W-1:0]    capture_slot;
  logic [SLOT_W-1:0]    capture_slot_next;

  logic [SW-1:0]        left_mag;
  logic [SW-1:0]        right_mag;
  logic signed [SW-1:0] dom;
  logic [SW-1:0]        dmag;
  logic signed [SW-1:0] base_max;
  logic signed [SW-1:0] base_min;
  logic [UW-1:0]        base_sum;
  logic [TW-1:0]        base_tally;
  logic [UW:0]          sum_wide;
  logic [TW:0]          tally_wide;
  logic [SLOT_W+IW-1:0] slot_ext;
  logic                 clip_seen;

  always_comb begin
    left_mag  = sgcpm_pkg::mag24(left_pcm);
    right_mag = sgcpm_pkg::mag24(right_pcm);
    // Right channel wins a tie in magnitude.
    dom  = (left_mag > right_mag) ? left_pcm : right_pcm;
    dmag = (left_mag > right_mag) ? left_mag : right_mag;

    base_max   = batch_start ? sgcpm_pkg::MIN24 : running_max;
    base_min   = batch_start ? sgcpm_pkg::MAX24 : running_min;
    base_sum   = batch_start ? '0 : running_abs_sum;
    base_tally = batch_start ? '0 : clip_tally;

    running_max_next = (dom > base_max) ? dom : base_max;
    running_min_next = (dom < base_min) ? dom : base_min;

    sum_wide = {1'b0, base_sum} + (UW + 1)'(dmag);
    running_abs_sum_next = sum_wide[UW] ? sgcpm_pkg::SUM_LIMIT : sum_wide[UW-1:0];

    tally_wide = {1'b0, base_tally} + (TW + 1)'(left_clip) + (TW + 1)'(right_clip);
    clip_tally_next = tally_wide[TW] ? sgcpm_pkg::TALLY_LIMIT : tally_wide[TW-1:0];

    peak_hold_next = (dmag > peak_hold) ? dmag : peak_hold;

    capture_slot_next = (capture_slot == SLOT_LAST) ? '0 : capture_slot + SLOT_W'(1);

    slot_ext = {{IW{1'b0}}, capture_slot};

    clip_seen = adv && !batch_start && (left_clip || right_clip) &&
                (clip_tally != sgcpm_pkg::TALLY_LIMIT);

    stats.batch_clip_count = clip_tally_next;
    stats.batch_max        = running_max_next;
    stats.batch_min        = running_min_next;
    stats.batch_abs_sum    = running_abs_sum_next;
    stats.peak_level       = peak_hold_next;
    stats.capture_index    = slot_ext[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_hold       <= '0;
      running_max     <= sgcpm_pkg::MIN24;
      running_min     <= sgcpm_pkg::MAX24;
      running_abs_sum <= '0;
      clip_tally      <= '0;
      capture_slot    <= '0;
    end else if (adv) begin
      peak_hold       <= peak_hold_next;
      running_max     <= running_max_next;
      running_min     <= running_min_next;
      running_abs_sum <= running_abs_sum_next;
      clip_tally      <= clip_tally_next;
      capture_slot    <= capture_slot_next;
    end
  end

  `SGCPM_ASSERT_NEXT(a_peak_follows, adv && (dmag > peak_hold), peak_hold == $past(dmag), "peak missed")
  `SGCPM_ASSERT_NEXT(a_batch_first_frame, adv && batch_start, running_max == running_min, "no restart")
  `SGCPM_ASSERT_NEXT(a_tally_counts, clip_seen, clip_tally != $past(clip_tally), "clip was not counted")

endmodule

[hw/rtl/stereo_gain_clip_peak_meter.sv]
// Top level: stereo gain with saturation, clip counting and peak metering.
//
//   channel  direction  handshake                 payload
//   frame    in         frame_valid/frame_stall   frame (frame_t)
//   result   out        result_valid/result_stall result (result_t)
//   cfg      in         cfg_valid/cfg_ready       cfg_data (gain, unsigned Q1.14)
//
// One frame a cycle is taken while the result is not stalled; it passes the frame register, then the result register.
// The input register feeds the two multipliers and the meters, the result register takes them.
// Reset sets the gain to 0.5 and clears the meters; cfg_ready is always high.
// A stalled result holds the frame stage; frame_stall rises only when both stages are full.
module stereo_gain_clip_peak_meter #(
  parameter int CAPTURE_DEPTH = sgcpm_pkg::CAPTURE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  output logic                             frame_stall,
  input  sgcpm_pkg::frame_t                frame,
  output logic                             result_valid,
  input  logic                             result_stall,
  output sgcpm_pkg::result_t               result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sgcpm_pkg::GAIN_W-1:0]     cfg_data
);

  `include "stereo_gain_clip_peak_meter_assert.svh"

  localparam int WW = sgcpm_pkg::WORD_W;

  logic [sgcpm_pkg::GAIN_W-1:0] gain;
  logic                         s1_valid;
  logic                         s1_valid_next;
  sgcpm_pkg::frame_t            s1;
  logic                         out_adv;
  logic                         adv;
  logic                         accept;
  sgcpm_pkg::chan_t             left_chan;
  sgcpm_pkg::chan_t             right_chan;
  sgcpm_pkg::stats_t            stats;
  sgcpm_pkg::result_t           result_next;

  assign cfg_ready   = 1'b1;
  assign out_adv     = !result_valid || !result_stall;
  assign adv         = s1_valid && out_adv;
  assign frame_stall = s1_valid && !out_adv;
  assign accept      = frame_valid && !frame_stall;

  always_comb begin
    priority if (accept) begin
      s1_valid_next = 1'b1;
    end else if (out_adv) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= sgcpm_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
      if (out_adv) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= frame;
    end
    if (adv) begin
      result <= result_next;
    end
  end

  sgcpm_gain_chan u_left (
    .sample (s1.left_word[WW-1:WW-sgcpm_pkg::SAMPLE_W]),
    .gain   (gain),
    .chan   (left_chan)
  );

  sgcpm_gain_chan u_right (
    .sample (s1.right_word[WW-1:WW-sgcpm_pkg::SAMPLE_W]),
    .gain   (gain),
    .chan   (right_chan)
  );

  sgcpm_stats #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_stats (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .left_pcm    (s1.left_word[WW-1:WW-sgcpm_pkg::SAMPLE_W]),
    .right_pcm   (s1.right_word[WW-1:WW-sgcpm_pkg::SAMPLE_W]),
    .batch_start (s1.batch_start),
    .left_clip   (left_chan.clipped),
    .right_clip  (right_chan.clipped),
    .stats       (stats)
  );

  always_comb begin
    result_next.left_out         = left_chan.word_out;
    result_next.right_out        = right_chan.word_out;
    result_next.batch_clip_count = stats.batch_clip_count;
    result_next.batch_max        = stats.batch_max;
    result_next.batch_min        = stats.batch_min;
    result_next.batch_abs_sum    = stats.batch_abs_sum;
    result_next.peak_level       = stats.peak_level;
    result_next.capture_index    = stats.capture_index;
  end

  `SGCPM_ASSERT_NEXT(a_accept_fills, accept, s1_valid, "request did not reach the frame stage")
  `SGCPM_ASSERT_NEXT(a_adv_shows, adv, result_valid, "frame stage moved on without a result")
  `SGCPM_ASSERT_SAME(a_stall_only_full, frame_stall, s1_valid && result_valid, "stall with a free stage")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the stereo gain, clip and peak meter, with a built-in predictor.
module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int GAIN_UNITY   = 16384;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 4;

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         frame_valid  = 1'b0;
  logic                         frame_stall;
  sgcpm_pkg::frame_t            frame        = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  sgcpm_pkg::result_t           result;
  logic                         cfg_valid    = 1'b0;
  logic                         cfg_ready;
  logic [sgcpm_pkg::GAIN_W-1:0] cfg_data     = '0;

  // Predicted meter state, kept in step with every accepted request.
  logic [sgcpm_pkg::GAIN_W-1:0] gain_now    = sgcpm_pkg::GAIN_RESET;
  int                           peak_now    = 0;
  int                           batch_hi    = int'(sgcpm_pkg::MIN24);
  int                           batch_lo    = int'(sgcpm_pkg::MAX24);
  longint                       abs_sum_now = 0;
  int                           clip_now    = 0;
  int                           slot_now    = 0;

  sgcpm_pkg::result_t expected_q[$];
  sgcpm_pkg::result_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int frames_sent   = 0;
  int gains_used    = 0;
  int tally_top     = 0;
  int input_stalls  = 0;
  int cycle_count   = 0;

  stereo_gain_clip_peak_meter dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Gain one channel: truncate toward zero, then clamp to symmetric full scale.
  function automatic logic [sgcpm_pkg::WORD_W-1:0] apply_gain(int s, output bit clipped);
    longint v;
    v = (longint'(s) * longint'(gain_now)) / GAIN_UNITY;
    clipped = 1'b0;
    if (v > longint'(sgcpm_pkg::MAX24)) begin
      v = longint'(sgcpm_pkg::MAX24);
      clipped = 1'b1;
    end else if (v < -longint'(sgcpm_pkg::MAX24)) begin
      v = -longint'(sgcpm_pkg::MAX24);
      clipped = 1'b1;
    end
    return 32'(v * 256);
  endfunction

  function automatic sgcpm_pkg::result_t predict_frame(sgcpm_pkg::frame_t f);
    sgcpm_pkg::result_t r;
    int ls, rs, lmag, rmag, dom, dmag;
    bit lclip, rclip;
    ls = $signed(f.left_word[31:8]);
    rs = $signed(f.right_word[31:8]);
    if (f.batch_start) begin
      batch_hi = int'(sgcpm_pkg::MIN24);
      batch_lo = int'(sgcpm_pkg::MAX24);
      abs_sum_now = 0;
      clip_now = 0;
    end
    r.capture_index = slot_now[sgcpm_pkg::INDEX_W-1:0];
    slot_now = (slot_now + 1) % sgcpm_pkg::CAPTURE_DEPTH_DEFAULT;
    r.left_out = apply_gain(ls, lclip);
    r.right_out = apply_gain(rs, rclip);
    if (lclip && clip_now < int'(sgcpm_pkg::TALLY_LIMIT)) clip_now++;
    if (rclip && clip_now < int'(sgcpm_pkg::TALLY_LIMIT)) clip_now++;
    lmag = (ls < 0) ? -ls : ls;
    rmag = (rs < 0) ? -rs : rs;
    // The right channel wins when the magnitudes are equal.
    dom = (lmag > rmag) ? ls : rs;
    dmag = (lmag > rmag) ? lmag : rmag;
    if (dom > batch_hi) batch_hi = dom;
    if (dom < batch_lo) batch_lo = dom;
    abs_sum_now += dmag;
    if (abs_sum_now > longint'(sgcpm_pkg::SUM_LIMIT)) abs_sum_now = longint'(sgcpm_pkg::SUM_LIMIT);
    if (dmag > peak_now) peak_now = dmag;
    r.batch_clip_count = clip_now[sgcpm_pkg::TALLY_W-1:0];
    r.batch_max = batch_hi[sgcpm_pkg::SAMPLE_W-1:0];
    r.batch_min = batch_lo[sgcpm_pkg::SAMPLE_W-1:0];
    r.batch_abs_sum = abs_sum_now[sgcpm_pkg::SUM_W-1:0];
    r.peak_level = peak_now[sgcpm_pkg::SAMPLE_W-1:0];
    return r;
  endfunction

  task automatic note_error(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endtask

  task automatic check_field(string what, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val)
      note_error($sformatf("Result %0d, %s: expected %h, got %h",
                           results_seen, what, exp_val, act_val));
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && frame_valid && frame_stall) input_stalls++;
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        note_error($sformatf("Result %0d arrived with no request pending", results_seen));
      end else begin
        want = expected_q.pop_front();
        check_field("left_out", want.left_out, result.left_out);
        check_field("right_out", want.right_out, result.right_out);
        check_field("batch_clip_count", want.batch_clip_count, result.batch_clip_count);
        check_field("batch_max", want.batch_max, result.batch_max);
        check_field("batch_min", want.batch_min, result.batch_min);
        check_field("batch_abs_sum", want.batch_abs_sum, result.batch_abs_sum);
        check_field("peak_level", want.peak_level, result.peak_level);
        check_field("capture_index", want.capture_index, result.capture_index);
        if (int'(want.batch_clip_count) > tally_top) tally_top = want.batch_clip_count;
      end
      results_seen++;
    end
  end

  // Valid stays high from one request to the next unless the sender chooses a gap.
  task automatic send_frame(sgcpm_pkg::frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame <= f;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    expected_q.push_back(predict_frame(f));
    frames_sent++;
  endtask

  task automatic wait_drained();
    frame_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(logic [sgcpm_pkg::GAIN_W-1:0] g);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gain_now = g;
    gains_used++;
  endtask

  function automatic logic [sgcpm_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 15'(GAIN_UNITY);
      3: return sgcpm_pkg::GAIN_RESET;
      default: return 15'($urandom_range(32767));
    endcase
  endfunction

  function automatic logic [sgcpm_pkg::WORD_W-1:0] pick_word();
    logic [7:0] low, b;
    low = 8'($urandom());
    b = 8'($urandom());
    case ($urandom_range(7))
      0: return {24'h7FFFFF, low};
      1: return {24'h800000, low};
      2: return {{16{b[7]}}, b, low};
      // Between half and full scale, where doubling gains sit on the clip edge.
      3: return {($urandom_range(1) != 0) ? 2'b01 : 2'b10, 22'($urandom()), low};
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Reset gain of one half.
    send_frame('{32'h7FFFFFFF, 32'h80000000, 1'b1});
    send_frame('{32'h00000000, 32'h00000000, 1'b0});
    send_frame('{32'h00001000, 32'hFFFFF000, 1'b0});
    send_frame('{32'hFFFFF0AB, 32'h000010CD, 1'b0});
    send_frame('{32'h000001FF, 32'hFFFFFFFF, 1'b0});
    wait_drained();
    write_gain(15'(GAIN_UNITY));
    // At unity the most negative sample still clips to negative full scale.
    send_frame('{32'h80000000, 32'h00000000, 1'b1});
    send_frame('{32'h7FFFFF00, 32'h80000100, 1'b0});
    send_frame('{32'h00000100, 32'hFFFFFF00, 1'b0});
    wait_drained();
    write_gain('1);
    send_frame('{32'h40000000, 32'hC0000000, 1'b1});
    send_frame('{32'h40008000, 32'hBFFF8000, 1'b0});
    send_frame('{32'h7FFFFFFF, 32'h80000000, 1'b0});
    send_frame('{32'h00000100, 32'hFFFFFF00, 1'b0});
    wait_drained();
    write_gain('0);
    send_frame('{32'h7FFFFFFF, 32'h80000000, 1'b1});
    send_frame('{32'h5A5AA5A5, 32'hA5A55A5A, 1'b0});
    wait_drained();
    write_gain(15'd1);
    send_frame('{32'h7FFFFFFF, 32'h80000000, 1'b0});
    send_frame('{32'h12345678, 32'h87654321, 1'b1});
    wait_drained();
  endtask

  // A long batch at maximum gain: the magnitude sum must saturate and the clip tally runs high.
  task automatic test_meter_saturation();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    write_gain('1);
    send_frame('{32'h7FFFFFFF, 32'h80000000, 1'b1});
    for (int i = 0; i < 150; i++)
      send_frame('{(i % 2 != 0) ? 32'h7FFFFFFF : 32'h80000000, $urandom(), 1'b0});
    send_frame('{32'h7FFFFFFF, 32'h80000000, 1'b1});
    wait_drained();
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct, int items);
    int batch_left;
    sgcpm_pkg::frame_t f;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    batch_left = 0;
    for (int i = 0; i < items; i++) begin
      if (i % (items / 4) == 0) begin
        wait_drained();
        write_gain(pick_gain());
      end
      // Mostly nominal batches of 64 frames, some short or overlong ones.
      if (batch_left == 0) begin
        f.batch_start = 1'b1;
        batch_left = ($urandom_range(7) == 0) ? $urandom_range(1, 150) : 64;
      end else begin
        f.batch_start = ($urandom_range(49) == 0);
      end
      batch_left--;
      f.left_word = pick_word();
      f.right_word = pick_word();
      if ($urandom_range(9) == 0)
        f.right_word = {($urandom_range(1) != 0) ? f.left_word[31:8] : 24'(-f.left_word[31:8]),
                        8'($urandom())};
      send_frame(f);
    end
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    sgcpm_pkg::frame_t f;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 120;
    for (int i = 0; i < 80; i++) begin
      f.left_word = pick_word();
      f.right_word = pick_word();
      f.batch_start = (i % 32 == 0);
      send_frame(f);
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_meter_saturation();
    test_random_phase(14, 85, 480);
    test_random_phase(85, 14, 480);
    test_backpressure();
    test_random_phase(0, 0, 480);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d frames across %0d gain settings.",
             results_seen, frames_sent, gains_used);
    $display("Clip tally reached %0d; the input was held off on %0d cycles; %0d mismatches.",
             tally_top, input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sgcpm_pkg.sv
hw/rtl/sgcpm_gain_chan.sv
hw/rtl/sgcpm_stats.sv
hw/rtl/stereo_gain_clip_peak_meter.sv
sim/tb_top.sv
